@@ hdl/urxrcf_pkg.sv @@
`timescale 1ns / 1ps

package urxrcf_pkg;

  localparam int RING_DEPTH = 32;
  localparam int IDX_W      = $clog2(RING_DEPTH);

  localparam logic [1:0] MODE_PASS  = 2'd0;
  localparam logic [1:0] MODE_SWAP  = 2'd1;
  localparam logic [1:0] MODE_UPPER = 2'd2;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  typedef struct packed {
    logic       break_released;
    logic       break_clear;
    logic       char_ready;
    logic [7:0] char_value;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [1:0] mode, input logic [7:0] c);
    logic is_upper;
    logic is_lower;
    logic [7:0] res;
    is_upper = (c inside {[CH_UPPER_A:CH_UPPER_Z]});
    is_lower = (c inside {[CH_LOWER_A:CH_LOWER_Z]});
    res = c;
    case (mode)
      MODE_SWAP: begin
        if (is_upper) res = c + CASE_DELTA;
        else if (is_lower) res = c - CASE_DELTA;
      end
      MODE_UPPER: begin
        if (is_lower) res = c - CASE_DELTA;
      end
      default: res = c;
    endcase
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] res;
    if (i == IDX_W'(RING_DEPTH - 1)) res = '0;
    else res = i + IDX_W'(1);
    return res;
  endfunction

endpackage

@@ hdl/uart_rx_ring_with_case_fold_top.sv @@
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | line_break, byte_valid, rx_byte, enable, take_char
// out_    | output    | out_valid/out_stall| break_released, break_clear, char_ready, char_value
// cfg_    | input     | cfg_valid/cfg_ready| case_mode (2 bits)
//
// One item per cycle while in_stall is low; each result is registered.
// Ring push, pop and case fold are done in the accept cycle against the ring flops.
// A two-entry output buffer (output register plus skid) lets an item in while a
// result waits; in_stall rises only when both entries are full.
// Synchronous active-low reset empties ring and hold slot and sets case_mode to 0.
module uart_rx_ring_with_case_fold_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_line_break,
  input  logic       in_byte_valid,
  input  logic [7:0] in_rx_byte,
  input  logic       in_enable,
  input  logic       in_take_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_break_released,
  output logic       out_break_clear,
  output logic       out_char_ready,
  output logic [7:0] out_char_value,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_case_mode
);

  localparam int IDX_W = urxrcf_pkg::IDX_W;

  logic [7:0]       ring_r [urxrcf_pkg::RING_DEPTH];
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic             slot_full_r, slot_full_nxt;
  logic [7:0]       slot_char_r, slot_char_nxt;
  logic             break_seen_r;
  logic [1:0]       case_mode_r;

  urxrcf_pkg::result_t out_r, skid_r, res_nxt;
  logic                out_valid_r, skid_valid_r;

  logic             accept;
  logic             out_pop;
  logic             slot_kept;
  logic             push;
  logic             pop;
  logic [IDX_W-1:0] wr_adv;
  logic [IDX_W-1:0] rd_adv;
  logic [7:0]       pop_byte;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid & ~skid_valid_r;
  assign out_pop   = out_valid_r & ~out_stall;

  always_comb begin
    slot_kept  = slot_full_r & ~in_take_char;
    wr_adv     = urxrcf_pkg::next_idx(wr_idx_r);
    push       = in_enable & in_byte_valid & (wr_adv != rd_idx_r);
    wr_idx_nxt = push ? wr_adv : wr_idx_r;
    rd_adv     = urxrcf_pkg::next_idx(rd_idx_r);
    pop        = in_enable & ~slot_kept & (wr_idx_nxt != rd_idx_r);
    rd_idx_nxt = pop ? rd_adv : rd_idx_r;
    // byte pushed into an empty ring is popped in the same item if the hold slot is free
    pop_byte   = (push && rd_adv == wr_idx_nxt) ? in_rx_byte : ring_r[rd_adv];
    slot_char_nxt = pop ? urxrcf_pkg::fold_case(case_mode_r, pop_byte) : slot_char_r;
    slot_full_nxt = slot_kept | pop;

    res_nxt.break_released = ~in_line_break & break_seen_r;
    res_nxt.break_clear    = in_line_break;
    res_nxt.char_ready     = slot_full_nxt;
    res_nxt.char_value     = slot_full_nxt ? slot_char_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (accept && push) begin
      ring_r[wr_adv] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r     <= '0;
      wr_idx_r     <= '0;
      slot_full_r  <= 1'b0;
      slot_char_r  <= 8'd0;
      break_seen_r <= 1'b0;
      case_mode_r  <= urxrcf_pkg::MODE_PASS;
    end else begin
      if (cfg_valid && cfg_ready) case_mode_r <= cfg_case_mode;
      if (accept) begin
        rd_idx_r     <= rd_idx_nxt;
        wr_idx_r     <= wr_idx_nxt;
        slot_full_r  <= slot_full_nxt;
        slot_char_r  <= slot_char_nxt;
        break_seen_r <= in_line_break;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_pop) begin
        out_valid_r  <= skid_valid_r | accept;
        skid_valid_r <= 1'b0;
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_pop) begin
      out_r <= skid_valid_r ? skid_r : res_nxt;
    end else if (accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_break_released = out_r.break_released;
  assign out_break_clear    = out_r.break_clear;
  assign out_char_ready     = out_r.char_ready;
  assign out_char_value     = out_r.char_value;

endmodule

@@ hdl/urxrcf_checker.sv @@
`timescale 1ns / 1ps

module urxrcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_break_released,
  input logic       out_break_clear,
  input logic       out_char_ready,
  input logic [7:0] out_char_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_value)
      && $stable(out_char_ready) && $stable(out_break_clear)
      && $stable(out_break_released))
    else $error("stalled item changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_ready |-> out_char_value == 8'd0)
    else $error("empty hold slot shows a character");

  a_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_break_released |-> !out_break_clear)
    else $error("break release while break still present");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("item or stall left over after reset");

endmodule

bind uart_rx_ring_with_case_fold_top urxrcf_checker u_urxrcf_checker (.*);

@@ tb/sv/tb_uart_rx_ring_with_case_fold_top.sv @@
`timescale 1ns / 1ps

module tb_uart_rx_ring_with_case_fold_top;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic       brk;
    logic       bv;
    logic [7:0] b;
    logic       en;
    logic       take;
  } tick_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_line_break = 1'b0;
  logic       in_byte_valid = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_enable = 1'b0;
  logic       in_take_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_break_released;
  logic       out_break_clear;
  logic       out_char_ready;
  logic [7:0] out_char_value;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_case_mode = urxrcf_pkg::MODE_PASS;

  uart_rx_ring_with_case_fold_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_line_break      (in_line_break),
    .in_byte_valid      (in_byte_valid),
    .in_rx_byte         (in_rx_byte),
    .in_enable          (in_enable),
    .in_take_char       (in_take_char),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_break_released (out_break_released),
    .out_break_clear    (out_break_clear),
    .out_char_ready     (out_char_ready),
    .out_char_value     (out_char_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_case_mode      (cfg_case_mode)
  );

  // expected block state
  logic [1:0]                  fold_mode = urxrcf_pkg::MODE_PASS;
  logic                        brk_seen = 1'b0;
  logic [7:0]                  ring_bytes [urxrcf_pkg::RING_DEPTH];
  logic [urxrcf_pkg::IDX_W-1:0] rd_idx = '0;
  logic [urxrcf_pkg::IDX_W-1:0] wr_idx = '0;
  logic                        slot_full = 1'b0;
  logic [7:0]                  slot_char = 8'h00;

  tick_t               pending_ticks[$];
  urxrcf_pkg::result_t expected_status[$];
  tick_t               next_tick;

  logic in_fired = 1'b0;
  logic quiet = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   errors = 0;
  int   ticks_sent = 0;
  int   results_seen = 0;
  int   full_drops = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] folded(input logic [1:0] m, input logic [7:0] c);
    logic up;
    logic lo;
    up = (c >= urxrcf_pkg::CH_UPPER_A) && (c <= urxrcf_pkg::CH_UPPER_Z);
    lo = (c >= urxrcf_pkg::CH_LOWER_A) && (c <= urxrcf_pkg::CH_LOWER_Z);
    if (m == urxrcf_pkg::MODE_SWAP && up) return c + urxrcf_pkg::CASE_DELTA;
    if ((m == urxrcf_pkg::MODE_SWAP || m == urxrcf_pkg::MODE_UPPER) && lo)
      return c - urxrcf_pkg::CASE_DELTA;
    return c;
  endfunction

  task automatic predict_tick();
    urxrcf_pkg::result_t          r;
    logic [urxrcf_pkg::IDX_W-1:0] nxt;
    if (in_take_char) slot_full = 1'b0;
    r.break_released = !in_line_break && brk_seen;
    r.break_clear = in_line_break;
    brk_seen = in_line_break;
    if (in_enable) begin
      nxt = wr_idx + 1'b1;
      if (in_byte_valid) begin
        if (nxt != rd_idx) begin
          wr_idx = nxt;
          ring_bytes[wr_idx] = in_rx_byte;
        end else begin
          full_drops++;
        end
      end
      if (!slot_full && wr_idx != rd_idx) begin
        rd_idx = rd_idx + 1'b1;
        slot_char = folded(fold_mode, ring_bytes[rd_idx]);
        slot_full = 1'b1;
      end
    end
    r.char_ready = slot_full;
    r.char_value = slot_full ? slot_char : 8'h00;
    expected_status.push_back(r);
  endtask

  task automatic check_field(input string fld, input logic [7:0] e, input logic [7:0] a);
    if (a !== e) begin
      errors++;
      $display("%0t: %s mismatch, expected %h got %h", $time, fld, e, a);
    end
  endtask

  // sender: one item at a time, held while stalled
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fired)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() != 0 && (quiet || $urandom_range(0, 5) != 0)) begin
        next_tick = pending_ticks.pop_front();
        in_valid <= 1'b1;
        in_line_break <= next_tick.brk;
        in_byte_valid <= next_tick.bv;
        in_rx_byte <= next_tick.b;
        in_enable <= next_tick.en;
        in_take_char <= next_tick.take;
      end else begin
        in_valid <= 1'b0;
        if (!quiet && pending_ticks.size() != 0) in_gap <= $urandom_range(0, 4);
      end
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      out_gap <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // accept tracking, prediction and result checking
  always @(posedge clk) begin
    urxrcf_pkg::result_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_tick();
        ticks_sent++;
      end
      in_fired <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, got %b %b %b %h", $time,
                   out_break_released, out_break_clear, out_char_ready, out_char_value);
        end else begin
          e = expected_status.pop_front();
          check_field("break_released", 8'(e.break_released), 8'(out_break_released));
          check_field("break_clear", 8'(e.break_clear), 8'(out_break_clear));
          check_field("char_ready", 8'(e.char_ready), 8'(out_char_ready));
          check_field("char_value", e.char_value, out_char_value);
        end
      end
    end else begin
      in_fired <= 1'b0;
    end
  end

  task automatic add_tick(input logic brk, input logic bv, input logic [7:0] b,
                          input logic en, input logic take);
    tick_t t;
    t.brk = brk;
    t.bv = bv;
    t.b = b;
    t.en = en;
    t.take = take;
    pending_ticks.push_back(t);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] edges [12];
    int         sel;
    edges = '{8'h00, 8'hFF, 8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61,
              8'h7A, 8'h7B, 8'h20, 8'h80};
    sel = $urandom_range(0, 2);
    if (sel == 0) return edges[$urandom_range(0, 11)];
    if (sel == 1) return 8'($urandom_range(8'h40, 8'h7F));
    return 8'($urandom_range(0, 255));
  endfunction

  // bursts of fill, drain, mixed traffic and noise, with break toggling
  task automatic queue_random_phase(input int n);
    int    kind;
    int    len;
    int    k;
    logic  brk;
    tick_t t;
    brk = 1'b0;
    k = 0;
    while (k < n) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(10, 60);
      for (int j = 0; j < len && k < n; j++) begin
        if ($urandom_range(0, 7) == 0) brk = ~brk;
        t.brk = brk;
        t.b = pick_byte();
        case (kind)
          0, 1, 2: begin
            t.bv = $urandom_range(0, 9) != 0;
            t.take = $urandom_range(0, 9) == 0;
            t.en = $urandom_range(0, 9) != 0;
          end
          3, 4: begin
            t.bv = $urandom_range(0, 4) == 0;
            t.take = $urandom_range(0, 4) != 0;
            t.en = $urandom_range(0, 9) != 0;
          end
          9: begin
            t.bv = 1'($urandom_range(0, 1));
            t.take = 1'($urandom_range(0, 1));
            t.en = 1'($urandom_range(0, 1));
            t.brk = 1'($urandom_range(0, 1));
          end
          default: begin
            t.bv = 1'($urandom_range(0, 1));
            t.take = 1'($urandom_range(0, 1));
            t.en = $urandom_range(0, 6) != 0;
          end
        endcase
        pending_ticks.push_back(t);
        k++;
      end
    end
  endtask

  task automatic drain_and_settle();
    while (pending_ticks.size() != 0 || in_valid || expected_status.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_case_mode(input logic [1:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_case_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fold_mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [1:0] modes [6];
    modes = '{urxrcf_pkg::MODE_SWAP, urxrcf_pkg::MODE_UPPER, MODE_SPARE,
              urxrcf_pkg::MODE_PASS, urxrcf_pkg::MODE_UPPER, urxrcf_pkg::MODE_SWAP};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    write_case_mode(urxrcf_pkg::MODE_PASS);

    // directed: disabled ticks, break pulse, edge bytes, take and pop together
    add_tick(0, 0, 8'h00, 0, 0);
    add_tick(1, 0, 8'h00, 0, 0);
    add_tick(0, 0, 8'h00, 0, 0);
    add_tick(1, 1, 8'h41, 0, 0);
    add_tick(0, 0, 8'h00, 1, 1);
    add_tick(0, 1, 8'h00, 1, 0);
    add_tick(0, 1, 8'hFF, 1, 0);
    add_tick(0, 1, 8'h61, 1, 0);
    add_tick(0, 1, 8'h7A, 1, 0);
    add_tick(0, 1, 8'h5A, 1, 0);
    add_tick(0, 1, 8'h40, 1, 0);
    add_tick(0, 1, 8'h5B, 1, 0);
    add_tick(0, 1, 8'h60, 1, 0);
    add_tick(0, 1, 8'h7B, 1, 0);
    add_tick(0, 0, 8'hAA, 1, 1);
    add_tick(0, 0, 8'h55, 0, 1);
    add_tick(0, 0, 8'h00, 1, 0);
    repeat (5) add_tick(0, 0, 8'h00, 1, 1);
    add_tick(1, 1, 8'h80, 1, 1);
    add_tick(1, 0, 8'h00, 1, 1);
    add_tick(0, 0, 8'h00, 1, 1);
    drain_and_settle();

    foreach (modes[i]) begin
      write_case_mode(modes[i]);
      if (i == 5) quiet = 1'b1;
      queue_random_phase(290);
      drain_and_settle();
    end

    if (expected_status.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_status.size());
    end
    $display("Ran %0d items over case modes 0 to 3 with ring fill and drain bursts;",
             ticks_sent);
    $display("%0d results compared, %0d bytes dropped on a full ring", results_seen,
             full_drops);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
